/* hw/rtl/rbd_pkg.sv */
// rbd_pkg: shared constants for the retry backoff decision block
// register indexes, datapath widths and fixed-point settings
// no dependencies
package rbd_pkg;

  // fixed-point and datapath sizing
  localparam int FRAC_BITS   = 8;
  localparam int DELAY_WIDTH = 32;
  localparam int CODE_COUNT  = 32;

  localparam int GROWTH_WIDTH = 16;
  localparam int ATT_WIDTH    = 16;
  localparam int CODE_WIDTH   = 5;
  localparam int MASK_WIDTH   = 32;
  localparam int CFG_WIDTH    = 32;
  localparam int CFG_IDX_W    = 3;

  localparam int PROD_WIDTH   = DELAY_WIDTH + GROWTH_WIDTH;
  localparam int SCALED_WIDTH = PROD_WIDTH - FRAC_BITS;

  // growth factor of exactly 1.0
  localparam logic [GROWTH_WIDTH-1:0] UNITY = GROWTH_WIDTH'(1) << FRAC_BITS;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BACKOFF_MODE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_INITIAL_DELAY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROWTH_FACTOR = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DELAY_CAP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ATTEMPT_LIMIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ANY_ERROR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_RETRY_MASK    = 3'd6;

  // stream payload widths, padded to whole bytes
  localparam int IN_BITS   = CODE_WIDTH + ATT_WIDTH;
  localparam int IN_BYTES  = (IN_BITS + 7) / 8;
  localparam int OUT_BITS  = 1 + (ATT_WIDTH + 1) + ATT_WIDTH + DELAY_WIDTH + 1;
  localparam int OUT_BYTES = (OUT_BITS + 7) / 8;

endpackage

/* hw/rtl/retry_backoff_decision.sv */
// retry_backoff_decision: capped exponential backoff retry decision
// one shared 32x16 multiplier stepped by a small sequencer
// depends on rbd_pkg
//
// Usage: a request on the s_* stream carries a status code and the number
// of attempts made so far. One result leaves on the m_* stream with the
// retry decision, the next attempt number, retries used, the wait in ticks
// and a config error flag. Configuration is written through cfg_we,
// cfg_index and cfg_data while the block is idle.
// Timing: with no growth the result is loaded at the request transfer and
// can leave in the next cycle. In exponential mode the shared multiplier runs
// one growth step a cycle, up to attempts_so_far - 1 steps plus one closing
// step, fewer when the delay hits the cap, the value is zero or the growth is
// exactly 1.0. One item is in flight at a time; s_tready is high only when
// idle, so a new request is taken only after the previous result has left.
// Reset: rst (synchronous) clears the sequencer and loads the register
// defaults (growth 1.0, attempt limit 1, all else zero).
// Stall: a finished result holds in the output register until m_tready;
// no new request is taken meanwhile.
module retry_backoff_decision (
  input  logic                               clk,
  input  logic                               rst,
  // configuration write port
  input  logic                               cfg_we,
  input  logic [rbd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rbd_pkg::CFG_WIDTH-1:0]      cfg_data,
  // request stream
  input  logic                               s_tvalid,
  output logic                               s_tready,
  // fields from bit 0: status_code[4:0], attempts_so_far[20:5], zero pad
  input  logic [rbd_pkg::IN_BYTES*8-1:0]     s_tdata,
  // result stream
  output logic                               m_tvalid,
  input  logic                               m_tready,
  // fields from bit 0: do_retry[0], next_attempt[17:1], retries_used[33:18],
  // wait_ticks[65:34], config_error[66], zero pad
  output logic [rbd_pkg::OUT_BYTES*8-1:0]    m_tdata
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_GROW = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam int DW = rbd_pkg::DELAY_WIDTH;
  localparam int AW = rbd_pkg::ATT_WIDTH;

  // configuration registers
  logic                              backoff_mode;
  logic [DW-1:0]                     initial_delay;
  logic [rbd_pkg::GROWTH_WIDTH-1:0]  growth_factor;
  logic [DW-1:0]                     delay_cap;
  logic [AW-1:0]                     attempt_limit;
  logic                              any_error_retries;
  logic [rbd_pkg::MASK_WIDTH-1:0]    retryable_mask;

  // sequencer and result registers
  logic [1:0]    state;
  logic [AW-1:0] att_q;
  logic [AW-1:0] iter;
  logic [DW-1:0] count;
  logic          do_retry;
  logic [AW:0]   next_attempt;
  logic [AW-1:0] retries_used;
  logic          config_error;

  logic [rbd_pkg::CODE_WIDTH-1:0]    in_code;
  logic [AW-1:0]                     in_att;
  logic                              ok_code;
  logic                              due;
  logic [rbd_pkg::PROD_WIDTH-1:0]    product;
  logic [rbd_pkg::SCALED_WIDTH-1:0]  scaled;
  logic                              scaled_hits_cap;
  logic [DW-1:0]                     count_capped;
  logic                              grow_stop;

  assign in_code = s_tdata[rbd_pkg::CODE_WIDTH-1:0];
  assign in_att  = s_tdata[rbd_pkg::CODE_WIDTH +: AW];

  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_DONE);

  // retry decision for the incoming request
  always_comb begin
    priority if (in_code == '0) begin
      ok_code = 1'b0;
    end else if (any_error_retries) begin
      ok_code = 1'b1;
    end else if (7'(in_code) < 7'(rbd_pkg::CODE_COUNT)) begin
      ok_code = retryable_mask[in_code];
    end else begin
      ok_code = 1'b0;
    end
  end

  assign due = (in_att != '0) && (in_att < attempt_limit) && ok_code;

  // shared growth step: count * growth, fraction dropped, saturated to cap
  assign product = rbd_pkg::PROD_WIDTH'(count) * rbd_pkg::PROD_WIDTH'(growth_factor);
  assign scaled  = product[rbd_pkg::PROD_WIDTH-1:rbd_pkg::FRAC_BITS];
  assign scaled_hits_cap = scaled >= rbd_pkg::SCALED_WIDTH'(delay_cap);
  assign count_capped = (count < delay_cap) ? count : delay_cap;
  assign grow_stop = (growth_factor == rbd_pkg::UNITY) || (iter >= att_q) || (count == '0);

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      backoff_mode      <= 1'b0;
      initial_delay     <= '0;
      growth_factor     <= rbd_pkg::UNITY;
      delay_cap         <= '0;
      attempt_limit     <= AW'(1);
      any_error_retries <= 1'b0;
      retryable_mask    <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rbd_pkg::REG_BACKOFF_MODE:  backoff_mode      <= cfg_data[0];
        rbd_pkg::REG_INITIAL_DELAY: initial_delay     <= cfg_data[DW-1:0];
        rbd_pkg::REG_GROWTH_FACTOR: growth_factor     <= cfg_data[rbd_pkg::GROWTH_WIDTH-1:0];
        rbd_pkg::REG_DELAY_CAP:     delay_cap         <= cfg_data[DW-1:0];
        rbd_pkg::REG_ATTEMPT_LIMIT: attempt_limit     <= cfg_data[AW-1:0];
        rbd_pkg::REG_ANY_ERROR:     any_error_retries <= cfg_data[0];
        rbd_pkg::REG_RETRY_MASK:    retryable_mask    <= cfg_data[rbd_pkg::MASK_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            if (due && backoff_mode && (growth_factor >= rbd_pkg::UNITY)) begin
              state <= ST_GROW;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_GROW: begin
          if (grow_stop || scaled_hits_cap) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (m_tready) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && s_tvalid) begin
      att_q <= in_att;
      iter  <= AW'(1);
      if (!due) begin
        do_retry     <= 1'b0;
        next_attempt <= {1'b0, in_att};
        retries_used <= (in_att == '0) ? '0 : in_att - AW'(1);
        count        <= '0;
        config_error <= 1'b0;
      end else if (backoff_mode && (growth_factor < rbd_pkg::UNITY)) begin
        do_retry     <= 1'b0;
        next_attempt <= {1'b0, in_att};
        retries_used <= in_att - AW'(1);
        count        <= '0;
        config_error <= 1'b1;
      end else begin
        do_retry     <= 1'b1;
        next_attempt <= {1'b0, in_att} + (AW+1)'(1);
        retries_used <= in_att;
        config_error <= 1'b0;
        if (backoff_mode) begin
          count <= initial_delay;
        end else begin
          count <= (initial_delay < delay_cap) ? initial_delay : delay_cap;
        end
      end
    end else if (state == ST_GROW) begin
      if (grow_stop) begin
        count <= count_capped;
      end else if (scaled_hits_cap) begin
        count <= delay_cap;
      end else begin
        count <= scaled[DW-1:0];
        iter  <= iter + AW'(1);
      end
    end
  end

  // result packing
  always_comb begin
    m_tdata = '0;
    m_tdata[0]                  = do_retry;
    m_tdata[1 +: AW+1]          = next_attempt;
    m_tdata[AW+2 +: AW]         = retries_used;
    m_tdata[2*AW+2 +: DW]       = count;
    m_tdata[2*AW+2+DW]          = config_error;
  end

`ifndef SYNTHESIS
  // request and result sides never open together
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(s_tready && m_tvalid))
    else $error("request accepted while a result is pending");

  // a config error never comes with a retry or a wait
  a_cfg_err_no_retry: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && config_error) |-> (!do_retry && count == '0))
    else $error("config error with retry or wait");

  // a nonzero wait only on retry
  a_wait_needs_retry: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && count != '0) |-> do_retry)
    else $error("wait without retry");

  // on retry the next attempt is one past the retries used
  a_retry_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && do_retry) |-> (next_attempt == {1'b0, retries_used} + (AW+1)'(1)))
    else $error("retry counts disagree");

  // wait never exceeds the cap once growth is done
  a_wait_capped: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && do_retry) |-> (count <= delay_cap))
    else $error("wait above cap");
`endif

endmodule
